// ----- hdl/pwbt_pkg.sv -----
// Shared types and constants for the pulse-width bit transmitter.
package pwbt_pkg;

    // Depth of the message bit store (power of two).
    localparam int FIFO_BITS = 1024;
    localparam int FIFO_AW   = $clog2(FIFO_BITS);
    localparam int CNT_W     = FIFO_AW + 1;

    localparam int TICK_W = 16;

    localparam logic [TICK_W-1:0] RST_BIT_PERIOD  = 16'd40;
    localparam logic [TICK_W-1:0] RST_ONE_PULSE   = 16'd20;
    localparam logic [TICK_W-1:0] RST_ZERO_PULSE  = 16'd32;
    localparam logic [TICK_W-1:0] RST_START_PULSE = 16'd170;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    // Operation class handed from front to back.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_LOAD,
        OP_TICK,
        OP_START
    } t_op;

    // Register indexes of the config port.
    typedef enum logic [1:0] {
        REG_BIT_PERIOD  = 2'd0,
        REG_ONE_PULSE   = 2'd1,
        REG_ZERO_PULSE  = 2'd2,
        REG_START_PULSE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] bit_period;
        logic [TICK_W-1:0] one_pulse;
        logic [TICK_W-1:0] zero_pulse;
        logic [TICK_W-1:0] start_pulse;
    } t_cfg;

    typedef struct packed {
        t_op  op;
        logic data_bit;
        logic last;
    } t_qent;

    // Front-to-back queue head.
    typedef struct packed {
        logic   valid;
        t_qent  ent;
    } t_q2b;

endpackage

// ----- hdl/pwbt_cfg.sv -----
// APB register file holding the four pulse timing registers.
module pwbt_cfg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output pwbt_pkg::t_cfg         o_cfg
);
    import pwbt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period  <= RST_BIT_PERIOD;
            r_cfg.one_pulse   <= RST_ONE_PULSE;
            r_cfg.zero_pulse  <= RST_ZERO_PULSE;
            r_cfg.start_pulse <= RST_START_PULSE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BIT_PERIOD:  r_cfg.bit_period  <= pwdata[TICK_W-1:0];
                REG_ONE_PULSE:   r_cfg.one_pulse   <= pwdata[TICK_W-1:0];
                REG_ZERO_PULSE:  r_cfg.zero_pulse  <= pwdata[TICK_W-1:0];
                REG_START_PULSE: r_cfg.start_pulse <= pwdata[TICK_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_BIT_PERIOD:  prdata = {16'd0, r_cfg.bit_period};
            REG_ONE_PULSE:   prdata = {16'd0, r_cfg.one_pulse};
            REG_ZERO_PULSE:  prdata = {16'd0, r_cfg.zero_pulse};
            REG_START_PULSE: prdata = {16'd0, r_cfg.start_pulse};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/pwbt_front.sv -----
// Input side: accepts beats, decodes the command and queues them for the sequencer.
module pwbt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [1:0]       i_cmd,
    input  logic             i_data_bit,
    input  logic             i_last,
    output pwbt_pkg::t_q2b   o_q2b,
    input  logic             i_pop
);
    import pwbt_pkg::*;

    localparam int QD = 2;

    t_qent      r_q [QD];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_qent      w_ent;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_ent.data_bit = i_data_bit;
        w_ent.last     = i_last;
        unique case (t_cmd'(i_cmd))
            CMD_LOAD:  w_ent.op = OP_LOAD;
            CMD_TICK:  w_ent.op = OP_TICK;
            CMD_START: w_ent.op = OP_START;
            default:   w_ent.op = OP_NOP;
        endcase
    end

    assign o_s_tready  = (r_cnt != 2'(QD));
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = i_pop && (r_cnt != 2'd0);
    assign o_q2b.valid = (r_cnt != 2'd0);
    assign o_q2b.ent   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD))
        else $error("front queue count out of range");

    a_full_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QD)) |-> !o_s_tready)
        else $error("ready while queue full");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("pop did not drain queue");

endmodule

// ----- hdl/pwbt_back.sv -----
// Sequencer: bit store, pulse phase timing and registered result beat.
module pwbt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pwbt_pkg::t_cfg   i_cfg,
    input  pwbt_pkg::t_q2b   i_q2b,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [7:0]       o_m_tdata
);
    import pwbt_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_ON,
        PH_START_OFF,
        PH_BIT_ON,
        PH_BIT_OFF
    } t_phase;

    function automatic logic [TICK_W-1:0] min1(input logic [TICK_W-1:0] v);
        min1 = (v == '0) ? TICK_W'(1) : v;
    endfunction

    // bit store: {last, data}
    logic [1:0]         mem [FIFO_BITS];
    logic [1:0]         r_head;

    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_ticks, n_ticks;
    logic [FIFO_AW-1:0] r_wptr,  n_wptr;
    logic [FIFO_AW-1:0] r_rptr,  n_rptr;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic               r_out_valid;
    logic [4:0]         r_out,   n_out;

    logic               w_adv;
    logic               w_we;
    logic               w_ovf, w_msg, w_all;
    logic [TICK_W:0]    w_t1;
    logic [TICK_W-1:0]  w_pulse;
    logic [TICK_W-1:0]  w_off;
    logic [CNT_W-1:0]   w_cnt_dec;

    assign w_adv   = i_q2b.valid && (!r_out_valid || i_m_tready);
    assign o_pop   = w_adv;
    assign w_t1    = {1'b0, r_ticks} + (TICK_W+1)'(1);
    assign w_pulse = r_head[0] ? min1(i_cfg.one_pulse) : min1(i_cfg.zero_pulse);
    assign w_off   = (i_cfg.bit_period > w_pulse) ? (i_cfg.bit_period - w_pulse)
                                                  : TICK_W'(1);
    assign w_cnt_dec = (r_cnt != '0) ? (r_cnt - CNT_W'(1)) : r_cnt;

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_cnt   = r_cnt;
        w_we    = 1'b0;
        w_ovf   = 1'b0;
        w_msg   = 1'b0;
        w_all   = 1'b0;
        if (w_adv) begin
            case (i_q2b.ent.op)
                OP_LOAD: begin
                    if (r_cnt == CNT_W'(FIFO_BITS)) begin
                        w_ovf = 1'b1;
                    end else begin
                        w_we   = 1'b1;
                        n_wptr = r_wptr + FIFO_AW'(1);
                        n_cnt  = r_cnt + CNT_W'(1);
                    end
                end
                OP_TICK: begin
                    n_ticks = w_t1[TICK_W-1:0];
                    unique case (r_phase)
                        PH_IDLE: n_ticks = r_ticks;
                        PH_START_ON: begin
                            if (w_t1 >= {1'b0, min1(i_cfg.start_pulse)}) begin
                                n_phase = PH_START_OFF;
                                n_ticks = '0;
                            end
                        end
                        PH_START_OFF: begin
                            if (w_t1 >= {1'b0, min1(i_cfg.one_pulse)}) begin
                                n_phase = PH_BIT_ON;
                                n_ticks = '0;
                            end
                        end
                        PH_BIT_ON: begin
                            if (w_t1 >= {1'b0, w_pulse}) begin
                                n_phase = PH_BIT_OFF;
                                n_ticks = '0;
                            end
                        end
                        PH_BIT_OFF: begin
                            if (w_t1 >= {1'b0, w_off}) begin
                                n_ticks = '0;
                                n_rptr  = r_rptr + FIFO_AW'(1);
                                n_cnt   = w_cnt_dec;
                                if (r_head[1] || w_cnt_dec == '0) begin
                                    w_msg = 1'b1;
                                    if (w_cnt_dec == '0) begin
                                        w_all   = 1'b1;
                                        n_phase = PH_IDLE;
                                    end else begin
                                        n_phase = PH_START_ON;
                                    end
                                end else begin
                                    n_phase = PH_BIT_ON;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_ticks = '0;
                        end
                    endcase
                end
                OP_START: begin
                    if (r_phase == PH_IDLE && r_cnt != '0) begin
                        n_phase = PH_START_ON;
                        n_ticks = '0;
                    end
                end
                default: ;
            endcase
        end
        n_out = {w_ovf, w_all, w_msg, (n_phase != PH_IDLE),
                 (n_phase == PH_START_ON || n_phase == PH_BIT_ON)};
    end

    // Head entry always mirrors mem[rptr]; bypass a write that lands there.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_wptr] <= {i_q2b.ent.last, i_q2b.ent.data_bit};
        end
        if (w_we && r_wptr == n_rptr) begin
            r_head <= {i_q2b.ent.last, i_q2b.ent.data_bit};
        end else begin
            r_head <= mem[n_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_cnt   <= n_cnt;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(FIFO_BITS))
        else $error("bit store count overflow");

    a_busy_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_cnt != '0))
        else $error("transmitting with empty bit store");

    a_all_implies_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3]) |-> (o_m_tdata[2] && !o_m_tdata[1]))
        else $error("all_sent without message_sent or while busy");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != CNT_W'(FIFO_BITS)) |->
            ((r_wptr - r_rptr) == r_cnt[FIFO_AW-1:0]))
        else $error("bit store pointers disagree with count");

endmodule

// ----- hdl/pulse_width_bit_transmitter_top.sv -----
// Top level of the pulse-width bit transmitter.
//
//  channel   dir   handshake            payload
//  s (in)    in    i_s_tvalid/o_s_tready tuser[1:0]=cmd, tdata[0]=data_bit, tlast=end_of_message
//  m (out)   out   o_m_tvalid/i_m_tready tdata[4:0]=line_active..overflow
//  apb cfg   in    psel/penable/pready   4 x 16-bit timing regs at byte addr 0,4,8,12
//
// Every input beat gives exactly one output beat. One beat per clock sustained while
// i_m_tready holds: the sequencer retires one command per cycle unless the output stalls,
// using its single bit-store write port and one registered head read.
// An accepted input beat is first written into the front queue; the result register loads
// when the sequencer pops it, and the result beat is offered from that register.
// Reset is synchronous, active low; the bit store contents are not cleared.
// A stalled output holds its beat while the two-entry front queue keeps
// accepting; o_s_tready drops only when that queue is full.
module pulse_width_bit_transmitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] data_bit, [7:1] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    input  logic        i_s_tlast,   // end_of_message
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] line_active [1] busy_res [2] message_sent
                                     // [3] all_sent [4] overflow [7:5] zero
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pwbt_pkg::*;

    t_cfg w_cfg;
    t_q2b w_q2b;
    logic w_pop;

    pwbt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // front: accept and decode beats into the command queue
    pwbt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_data_bit (i_s_tdata[0]),
        .i_last     (i_s_tlast),
        .o_q2b      (w_q2b),
        .i_pop      (w_pop)
    );

    // back: bit store, phase sequencer, result register
    pwbt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q2b      (w_q2b),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
